[rtl/core/swdr_pkg.sv]
// Shared types and codes for the stack with duplicate removal.
// Used by stack_with_duplicate_removal; no dependencies.
package swdr_pkg;

  // Default stack depth in entries
  localparam int unsigned DepthDefault = 16;

  // Word width of one stack entry
  localparam int unsigned WordW = 32;

  // Request codes, carried on s_axis_tuser
  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_POP   = 2'd1;
  localparam logic [1:0] REQ_PEEK  = 2'd2;
  localparam logic [1:0] REQ_DEDUP = 2'd3;

  // Status codes returned with every result
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  // One result transaction, read_value in the lowest bits
  typedef struct packed {
    logic [3:0]               removed_count;
    logic                     is_full;
    logic                     is_empty;
    logic [4:0]               entry_count;
    logic [1:0]               status;
    logic signed [WordW-1:0]  read_value;
  } result_t;

endpackage

[rtl/core/swdr_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module swdr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write on request, read every cycle into the output register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/stack_with_duplicate_removal.sv]
// Bounded LIFO stack of 32-bit words with duplicate removal; uses swdr_pkg, swdr_ram.
// Push and any refused request give their result in the cycle after acceptance;
// pop and peek first pass the registered read of the entry RAM and the S_RDOUT state.
// Duplicate removal walks the n held entries with one compare unit on one RAM read
// port; no new transaction is taken meanwhile. Throughput: push or refused request
// 1 per cycle unless the receiver stalls; pop or peek holds off requests until its read.
// Reset (rst_ni low, asynchronous) empties the stack; RAM contents are not cleared.
module stack_with_duplicate_removal #(
  parameter int unsigned DEPTH = swdr_pkg::DepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request: tuser = req_type[1:0]; tdata = push_value[31:0]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,
  input  logic [31:0] s_axis_tdata,
  // Result: tdata = read_value[31:0], status[33:32], entry_count[38:34],
  //         is_empty[39], is_full[40], removed_count[44:41], zero[47:45]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned WW = swdr_pkg::WordW;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDOUT = 3'd1;
  localparam logic [2:0] S_RDI   = 3'd2;
  localparam logic [2:0] S_LDI   = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_WR    = 3'd5;

  logic [2:0]              state_q, state_d;
  logic [CW-1:0]           fill_q, fill_d;
  logic [AW-1:0]           i_q, i_d;
  logic [AW-1:0]           j_q, j_d;
  logic [CW-1:0]           kept_q, kept_d;
  logic signed [WW-1:0]    cand_q, cand_d;
  swdr_pkg::result_t       out_q, out_d;
  logic                    out_valid_q, out_valid_d;

  logic                    accept;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [WW-1:0]           ram_wdata;
  logic [AW-1:0]           ram_raddr;
  logic [WW-1:0]           ram_rdata;

  logic                    res_load;
  logic signed [WW-1:0]    res_value;
  logic [1:0]              res_status;
  logic [CW-1:0]           res_fill;
  logic [CW-1:0]           res_removed;
  logic [CW+4:0]           cnt_ext;
  logic [CW+3:0]           rm_ext;

  // Entry storage, entry 0 at the bottom
  swdr_ram #(
    .Width (WW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Take a request only when idle and the output register is free or draining
  assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Sequencer: stack access from idle, or the pairwise walk for duplicate removal
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    i_d         = i_q;
    j_d         = j_q;
    kept_d      = kept_q;
    cand_d      = cand_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = fill_q[AW-1:0];
    ram_wdata   = cand_q;
    ram_raddr   = i_q;
    res_load    = 1'b0;
    res_value   = '0;
    res_status  = swdr_pkg::ST_OK;
    res_fill    = fill_q;
    res_removed = '0;

    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (s_axis_tuser)
            swdr_pkg::REQ_PUSH: begin
              res_load = 1'b1;
              if (fill_q == CW'(DEPTH)) begin
                res_status = swdr_pkg::ST_OVERFLOW;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = fill_q[AW-1:0];
                ram_wdata = s_axis_tdata;
                fill_d    = fill_q + 1'b1;
                res_fill  = fill_q + 1'b1;
              end
            end
            swdr_pkg::REQ_POP: begin
              if (fill_q == '0) begin
                res_load   = 1'b1;
                res_status = swdr_pkg::ST_EMPTY;
              end else begin
                ram_raddr = AW'(fill_q - 1'b1);
                fill_d    = fill_q - 1'b1;
                state_d   = S_RDOUT;
              end
            end
            swdr_pkg::REQ_PEEK: begin
              if (fill_q == '0) begin
                res_load   = 1'b1;
                res_status = swdr_pkg::ST_EMPTY;
              end else begin
                ram_raddr = AW'(fill_q - 1'b1);
                state_d   = S_RDOUT;
              end
            end
            swdr_pkg::REQ_DEDUP: begin
              if (fill_q == '0) begin
                res_load   = 1'b1;
                res_status = swdr_pkg::ST_EMPTY;
              end else begin
                i_d     = '0;
                kept_d  = '0;
                state_d = S_RDI;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      // Capture the popped or peeked word
      S_RDOUT: begin
        res_load  = 1'b1;
        res_value = ram_rdata;
        state_d   = S_IDLE;
      end
      // Fetch the candidate entry
      S_RDI: begin
        ram_raddr = i_q;
        state_d   = S_LDI;
      end
      // Hold the candidate and start scanning the entries above it
      S_LDI: begin
        cand_d = ram_rdata;
        if ((CW'(i_q) + 1'b1) < fill_q) begin
          ram_raddr = i_q + 1'b1;
          j_d       = i_q + 1'b1;
          state_d   = S_CMP;
        end else begin
          state_d = S_WR;
        end
      end
      // Compare one higher entry; a match drops the candidate
      S_CMP: begin
        if (ram_rdata == cand_q) begin
          i_d     = i_q + 1'b1;
          state_d = S_RDI;
        end else if ((CW'(j_q) + 1'b1) < fill_q) begin
          ram_raddr = j_q + 1'b1;
          j_d       = j_q + 1'b1;
        end else begin
          state_d = S_WR;
        end
      end
      // Compact the survivor down; the top entry always survives and ends the walk
      S_WR: begin
        ram_we    = 1'b1;
        ram_waddr = kept_q[AW-1:0];
        ram_wdata = cand_q;
        kept_d    = kept_q + 1'b1;
        if ((CW'(i_q) + 1'b1) < fill_q) begin
          i_d     = i_q + 1'b1;
          state_d = S_RDI;
        end else begin
          fill_d      = kept_q + 1'b1;
          res_load    = 1'b1;
          res_fill    = kept_q + 1'b1;
          res_removed = fill_q - (kept_q + 1'b1);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Mask counts to their field widths
  assign cnt_ext = {5'b0, res_fill};
  assign rm_ext  = {4'b0, res_removed};

  // Build the next result
  always_comb begin
    out_d = out_q;
    if (res_load) begin
      out_d.read_value    = res_value;
      out_d.status        = res_status;
      out_d.entry_count   = cnt_ext[4:0];
      out_d.is_empty      = (res_fill == '0);
      out_d.is_full       = (res_fill == CW'(DEPTH));
      out_d.removed_count = rm_ext[3:0];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= res_load ? 1'b1 : out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    kept_q <= kept_d;
    cand_q <= cand_d;
    out_q  <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b0, out_q};

  // Fill level never passes the depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(DEPTH))
    else $error("fill level above depth");

  // Compaction never writes above the entry being examined
  a_kept_le_i: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR) |-> (kept_q <= CW'(i_q)))
    else $error("compaction overtook the scan");

  // Scan entries lie above the candidate and inside the stack
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> ((j_q > i_q) && (CW'(j_q) < fill_q)))
    else $error("scan index out of range");

  // A result is never produced while the previous one is held and not being taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && out_valid_q) |-> m_axis_tready)
    else $error("result register overwritten");

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for stack_with_duplicate_removal: sends push, pop, peek and
// duplicate-removal requests and checks every result against a behavioral stack.
// Depends on swdr_pkg and the stack_with_duplicate_removal RTL.
module testbench;

  localparam int unsigned StackDepth    = 16;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned TailCycles    = 12;
  localparam int unsigned ResultW       = $bits(swdr_pkg::result_t);

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // tuser: req_type[1:0]
  logic [1:0]  s_axis_tuser  = swdr_pkg::REQ_PUSH;
  // tdata: push_value[31:0]
  logic [31:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // tdata: read_value, status, entry_count, is_empty, is_full, removed_count, zero pad
  logic [47:0] m_axis_tdata;

  stack_with_duplicate_removal #(
    .DEPTH(StackDepth)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // Behavioral copy of the stack
  logic [31:0] stack_words [StackDepth];
  int unsigned stack_fill = 0;

  // Results predicted for accepted requests, oldest first
  swdr_pkg::result_t pending_results [$];

  bit          valid_held  = 1'b0;
  bit          no_idle     = 1'b0;
  int unsigned fail_count  = 0;
  int unsigned checked_count = 0;
  int unsigned refused_count = 0;
  int unsigned full_count  = 0;
  int unsigned dedup_drop_count = 0;
  int unsigned req_counts [4] = '{0, 0, 0, 0};
  int unsigned stall_left  = 0;
  int unsigned ready_roll;

  // Apply one request to the behavioral stack and return its result
  function automatic swdr_pkg::result_t stack_predict(logic [1:0] req, logic [31:0] word);
    swdr_pkg::result_t res;
    bit                marks [StackDepth];
    int unsigned       kept;
    res = '0;
    case (req)
      swdr_pkg::REQ_PUSH: begin
        if (stack_fill >= StackDepth) begin
          res.status = swdr_pkg::ST_OVERFLOW;
        end else begin
          stack_words[stack_fill] = word;
          stack_fill++;
        end
      end
      swdr_pkg::REQ_POP: begin
        if (stack_fill == 0) begin
          res.status = swdr_pkg::ST_EMPTY;
        end else begin
          stack_fill--;
          res.read_value = stack_words[stack_fill];
        end
      end
      swdr_pkg::REQ_PEEK: begin
        if (stack_fill == 0) res.status = swdr_pkg::ST_EMPTY;
        else res.read_value = stack_words[stack_fill - 1];
      end
      default: begin
        if (stack_fill == 0) begin
          res.status = swdr_pkg::ST_EMPTY;
        end else begin
          // mark every entry that has a copy above it
          for (int i = 0; i < stack_fill; i++) begin
            marks[i] = 1'b0;
            for (int j = i + 1; j < stack_fill; j++) begin
              if (stack_words[j] == stack_words[i]) marks[i] = 1'b1;
            end
          end
          // compact the survivors toward the bottom, order kept
          kept = 0;
          for (int i = 0; i < stack_fill; i++) begin
            if (!marks[i]) begin
              stack_words[kept] = stack_words[i];
              kept++;
            end
          end
          res.removed_count = 4'(stack_fill - kept);
          stack_fill = kept;
        end
      end
    endcase
    res.entry_count = 5'(stack_fill);
    res.is_empty    = (stack_fill == 0);
    res.is_full     = (stack_fill >= StackDepth);
    return res;
  endfunction

  // Sender gap: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Request code from percent weights; the remainder goes to duplicate removal
  function automatic logic [1:0] pick_request(int unsigned push_w, int unsigned pop_w,
                                              int unsigned peek_w);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < push_w) return swdr_pkg::REQ_PUSH;
    if (roll < push_w + pop_w) return swdr_pkg::REQ_POP;
    if (roll < push_w + pop_w + peek_w) return swdr_pkg::REQ_PEEK;
    return swdr_pkg::REQ_DEDUP;
  endfunction

  // Word to push: from a small pool that breeds duplicates, or fully random
  function automatic logic [31:0] pick_word(int unsigned pool_pct);
    if ($urandom_range(0, 99) < pool_pct) begin
      case ($urandom_range(0, 5))
        0:       return 32'hFFFF_FFFF;
        1:       return 32'h0000_0000;
        2:       return 32'h8000_0000;
        3:       return 32'h7FFF_FFFF;
        default: return 32'($urandom_range(1, 6));
      endcase
    end
    return $urandom;
  endfunction

  // Send one request transaction and record its predicted result
  task automatic send_request(input logic [1:0] req, input logic [31:0] word);
    int unsigned       gap;
    swdr_pkg::result_t want;
    gap = pick_gap();
    if (gap != 0 && valid_held) begin
      s_axis_tvalid <= 1'b0;
      valid_held = 1'b0;
    end
    repeat (gap) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= word;
    valid_held = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    want = stack_predict(req, word);
    pending_results.push_back(want);
    req_counts[req]++;
    if (want.status != swdr_pkg::ST_OK) refused_count++;
    if (want.is_full) full_count++;
    dedup_drop_count += want.removed_count;
  endtask

  // Hold off the sender until every predicted result has come back
  task automatic wait_for_results();
    if (valid_held) begin
      s_axis_tvalid <= 1'b0;
      valid_held = 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_field(input string name, input logic signed [63:0] want_v,
                              input logic signed [63:0] got_v);
    if (got_v !== want_v) begin
      $error("%s expected %0d actual %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  // Compare one result transaction with the oldest prediction
  task automatic check_result(input logic [47:0] data);
    swdr_pkg::result_t got;
    swdr_pkg::result_t want;
    got = data[ResultW-1:0];
    if (pending_results.size() == 0) begin
      $error("result with nothing pending: tdata %h", data);
      fail_count++;
      return;
    end
    want = pending_results.pop_front();
    checked_count++;
    report_field("read_value", want.read_value, got.read_value);
    report_field("status", want.status, got.status);
    report_field("entry_count", want.entry_count, got.entry_count);
    report_field("is_empty", want.is_empty, got.is_empty);
    report_field("is_full", want.is_full, got.is_full);
    report_field("removed_count", want.removed_count, got.removed_count);
    report_field("tdata padding", 0, data[47:ResultW]);
  endtask

  // Check every result transaction
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
  end

  // Receiver: random stalls, mostly short, a few long
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (no_idle) begin
      m_axis_tready <= 1'b1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 75) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        stall_left = (ready_roll < 96) ? $urandom_range(0, 2) : $urandom_range(14, 49);
      end
    end
  end

  // End the run when no transaction moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $error("no transaction for %0d cycles", WatchdogLimit);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Pop, peek and duplicate removal on an empty stack
  task automatic test_empty_requests();
    send_request(swdr_pkg::REQ_POP, 32'h1234_5678);
    send_request(swdr_pkg::REQ_PEEK, 32'hFFFF_FFFF);
    send_request(swdr_pkg::REQ_DEDUP, 32'h0000_0000);
  endtask

  // Fill to the top with extreme and repeated words, then overflow and peek
  task automatic test_fill_and_overflow();
    logic [31:0] fill_words [StackDepth] = '{
      32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
      32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000,
      32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 32'h0000_0007,
      32'h0000_0007, 32'h0000_0000, 32'h0000_0002, 32'h0000_0003
    };
    foreach (fill_words[i]) send_request(swdr_pkg::REQ_PUSH, fill_words[i]);
    send_request(swdr_pkg::REQ_PUSH, 32'hDEAD_BEEF);
    send_request(swdr_pkg::REQ_PEEK, 32'h0000_0000);
  endtask

  // Removal with duplicates (-1 among them), again with none left, then pop
  task automatic test_duplicate_removal();
    send_request(swdr_pkg::REQ_DEDUP, 32'hFFFF_FFFF);
    send_request(swdr_pkg::REQ_DEDUP, 32'h0000_0000);
    send_request(swdr_pkg::REQ_POP, 32'h0000_0000);
  endtask

  // Balanced random mix of all requests
  task automatic test_random_mixed(input int unsigned count);
    repeat (count) send_request(pick_request(40, 25, 20), pick_word(40));
  endtask

  // Alternate push-heavy and pop-heavy stretches to hit full and empty
  task automatic test_fill_drain_cycles(input int unsigned count);
    for (int k = 0; k < count; k++) begin
      if ((k / 40) % 2 == 0) send_request(pick_request(75, 10, 10), pick_word(40));
      else send_request(pick_request(10, 70, 10), pick_word(40));
    end
  endtask

  // Pooled words and frequent removals to build deep runs of duplicates
  task automatic test_dedup_heavy(input int unsigned count);
    repeat (count) send_request(pick_request(60, 10, 10), pick_word(90));
  endtask

  // No idling on either side
  task automatic test_back_to_back(input int unsigned count);
    no_idle = 1'b1;
    repeat (count) send_request(pick_request(45, 25, 15), pick_word(50));
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_requests();
    test_fill_and_overflow();
    test_duplicate_removal();
    wait_for_results();
    test_random_mixed(700);
    wait_for_results();
    test_fill_drain_cycles(500);
    test_dedup_heavy(400);
    wait_for_results();
    test_back_to_back(225);
    wait_for_results();
    repeat (TailCycles) @(posedge clk_i);

    $display("Sent %0d pushes, %0d pops, %0d peeks, %0d duplicate removals; %0d checked.",
             req_counts[swdr_pkg::REQ_PUSH], req_counts[swdr_pkg::REQ_POP],
             req_counts[swdr_pkg::REQ_PEEK], req_counts[swdr_pkg::REQ_DEDUP],
             checked_count);
    $display("Full stack seen %0d times, %0d refused requests, %0d duplicates dropped.",
             full_count, refused_count, dedup_drop_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
